FILE: rtl/flash_record_ring_manager_top_macros.svh
// ----------------------------------------------------------------------------
// flash record ring manager assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef FLASH_RECORD_RING_MANAGER_TOP_MACROS_SVH
`define FLASH_RECORD_RING_MANAGER_TOP_MACROS_SVH

// same-cycle implication
`define FRRM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frrm same-cycle check failed");

// next-cycle implication
`define FRRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frrm next-cycle check failed");

`endif

FILE: rtl/frrm_pkg.sv
// ----------------------------------------------------------------------------
// frrm_pkg
// shared types and constants of the flash record ring manager
// ----------------------------------------------------------------------------
package frrm_pkg;

  localparam int ADDR_W  = 24;
  localparam int COUNT_W = 16;
  localparam int TICK_W  = 32;
  localparam int LEN_W   = 8;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD = 8'd250;
  localparam logic [LEN_W-1:0] HDR_EXTRA   = 8'd4;

  localparam logic [ADDR_W-1:0]  REGION_START_RST = 24'd0;
  localparam logic [ADDR_W-1:0]  REGION_END_RST   = 24'd65536;
  localparam logic [COUNT_W-1:0] MAX_RECORDS_RST  = 16'd256;
  localparam logic [TICK_W-1:0]  WAIT_TICKS_RST   = 32'd10000;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_CONSUME = 2'd2,
    KIND_POLL    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_START = 2'd0,
    CFG_REGION_END   = 2'd1,
    CFG_MAX_RECORDS  = 2'd2,
    CFG_WAIT_TICKS   = 2'd3
  } cfg_idx_t;

endpackage

FILE: rtl/flash_record_ring_manager_top.sv
// a request is held in the request register, then its result in the result register
// throughput: one request per cycle, busy stays low; each request is one registered
//   pass through the pointer, count and timer logic
// results cannot be stalled; out_valid marks each result for one cycle
// reset: synchronous active-low rst_n clears pointers, count, timer and strobes and
//   loads the configuration defaults
// ----------------------------------------------------------------------------
// flash_record_ring_manager_top
// pointer, record count and upload timer bookkeeping for a ring of fixed-size
// flash records
// ----------------------------------------------------------------------------
`include "flash_record_ring_manager_top_macros.svh"

module flash_record_ring_manager_top #(
  parameter int RECORD_BYTES = 256,
  parameter int SECTOR_BYTES = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic [frrm_pkg::LEN_W-1:0]        in_payload_len,
  input  logic                              in_write_ok,
  input  logic [frrm_pkg::TICK_W-1:0]       in_now_ticks,
  output logic                              out_valid,
  output logic                              out_ok,
  output logic [frrm_pkg::ADDR_W-1:0]       out_flash_addr,
  output logic [frrm_pkg::LEN_W-1:0]        out_header_length,
  output logic [frrm_pkg::COUNT_W-1:0]      out_record_count,
  input  logic                              cfg_we,
  input  logic [frrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [frrm_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int ADDR_W  = frrm_pkg::ADDR_W;
  localparam int COUNT_W = frrm_pkg::COUNT_W;
  localparam int TICK_W  = frrm_pkg::TICK_W;
  localparam int LEN_W   = frrm_pkg::LEN_W;
  localparam int SUM_W   = ADDR_W + 1;

  localparam logic [SUM_W-1:0]  REC_SUM  = SUM_W'(RECORD_BYTES);
  localparam logic [SUM_W-1:0]  SEC_SUM  = SUM_W'(SECTOR_BYTES);
  localparam logic [ADDR_W-1:0] REC_ADDR = ADDR_W'(RECORD_BYTES);
  localparam logic [LEN_W-1:0]  HLEN_MAX = frrm_pkg::MAX_PAYLOAD + frrm_pkg::HDR_EXTRA;

  // exact division by the record size through a reciprocal multiply
  localparam int DIV_SHIFT  = SUM_W + $clog2(RECORD_BYTES);
  localparam int DIV_MULT_W = SUM_W + 1;
  localparam int PROD_W     = SUM_W + DIV_MULT_W;
  localparam int Q_W        = PROD_W - DIV_SHIFT;
  localparam int CMP_W      = (Q_W > COUNT_W) ? Q_W : COUNT_W;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
    DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(RECORD_BYTES) - 64'd1) / 64'(RECORD_BYTES));

  // configuration
  logic [ADDR_W-1:0]  region_start_r;
  logic [ADDR_W-1:0]  region_end_r;
  logic [COUNT_W-1:0] max_records_r;
  logic [TICK_W-1:0]  wait_ticks_r;

  // request stage
  logic               req_v_r;
  frrm_pkg::kind_t    kind_r;
  logic [LEN_W-1:0]   plen_r;
  logic               wok_r;
  logic [TICK_W-1:0]  now_r;

  // ring state
  logic [ADDR_W-1:0]  ra_r, ra_nxt;
  logic [ADDR_W-1:0]  wa_r, wa_nxt;
  logic [COUNT_W-1:0] held_r, held_nxt;
  logic [TICK_W-1:0]  mark_r, mark_nxt;
  logic               armed_r, armed_nxt;

  // result stage
  logic               out_valid_r;
  logic               out_ok_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [LEN_W-1:0]   out_hlen_r;
  logic [COUNT_W-1:0] out_count_r;

  // datapath
  logic [SUM_W-1:0]   wr_sum;
  logic               wrap;
  logic [SUM_W-1:0]   bound;
  logic               evict;
  logic [SUM_W-1:0]   span;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     drop;
  logic               drop_all;
  logic [ADDR_W-1:0]  wa_w;
  logic [ADDR_W-1:0]  ra_w;
  logic [COUNT_W-1:0] held_w;
  logic [LEN_W-1:0]   plen_cl;
  logic [TICK_W-1:0]  mark_eff;
  logic [TICK_W-1:0]  elapsed;
  logic               poll_due;
  logic               ok_c;
  logic [ADDR_W-1:0]  addr_c;
  logic [LEN_W-1:0]   hlen_c;

  // check helpers
  logic               is_wr, is_rd, is_cons, is_poll;
  logic               ring_empty;
  logic               hlen_in_range;

  assign busy = 1'b0;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= frrm_pkg::REGION_START_RST;
      region_end_r   <= frrm_pkg::REGION_END_RST;
      max_records_r  <= frrm_pkg::MAX_RECORDS_RST;
      wait_ticks_r   <= frrm_pkg::WAIT_TICKS_RST;
    end else if (cfg_we) begin
      case (frrm_pkg::cfg_idx_t'(cfg_index))
        frrm_pkg::CFG_REGION_START: region_start_r <= cfg_wdata[ADDR_W-1:0];
        frrm_pkg::CFG_REGION_END:   region_end_r   <= cfg_wdata[ADDR_W-1:0];
        frrm_pkg::CFG_MAX_RECORDS:  max_records_r  <= cfg_wdata[COUNT_W-1:0];
        frrm_pkg::CFG_WAIT_TICKS:   wait_ticks_r   <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else begin
      req_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r <= frrm_pkg::kind_t'(in_kind);
      plen_r <= in_payload_len;
      wok_r  <= in_write_ok;
      now_r  <= in_now_ticks;
    end
  end

  // write wrap and sector eviction, payload clamp and poll timer
  always_comb begin
    wr_sum   = {1'b0, wa_r} + REC_SUM;
    wrap     = wr_sum >= {1'b0, region_end_r};
    bound    = {1'b0, region_start_r} + SEC_SUM;
    evict    = {1'b0, ra_r} < bound;
    span     = bound - {1'b0, ra_r};
    prod     = PROD_W'(span) * PROD_W'(DIV_MULT);
    drop     = prod[PROD_W-1:DIV_SHIFT];
    drop_all = CMP_W'(drop) >= CMP_W'(held_r);
    wa_w     = wrap ? region_start_r : wa_r;
    ra_w     = ra_r;
    held_w   = held_r;
    if (wrap && evict) begin
      ra_w   = bound[ADDR_W-1:0];
      held_w = drop_all ? '0 : held_r - COUNT_W'(drop);
    end
    plen_cl  = (plen_r > frrm_pkg::MAX_PAYLOAD) ? frrm_pkg::MAX_PAYLOAD : plen_r;
    mark_eff = armed_r ? mark_r : now_r;
    elapsed  = now_r - mark_eff;
    poll_due = elapsed >= wait_ticks_r;
  end

  // per-request state update
  always_comb begin
    ra_nxt    = ra_r;
    wa_nxt    = wa_r;
    held_nxt  = held_r;
    mark_nxt  = mark_r;
    armed_nxt = armed_r;
    ok_c      = 1'b0;
    addr_c    = ra_r;
    hlen_c    = '0;
    if (req_v_r) begin
      case (kind_r)
        frrm_pkg::KIND_WRITE: begin
          ra_nxt = ra_w;
          addr_c = wa_w;
          hlen_c = plen_cl + frrm_pkg::HDR_EXTRA;
          if (wok_r) begin
            wa_nxt   = wa_w + REC_ADDR;
            held_nxt = (held_w >= max_records_r) ? max_records_r : held_w + COUNT_W'(1);
            ok_c     = 1'b1;
          end else begin
            wa_nxt   = wa_w;
            held_nxt = held_w;
          end
        end
        frrm_pkg::KIND_READ: begin
          if (ra_r >= region_end_r) begin
            ra_nxt = region_start_r;
            addr_c = region_start_r;
            ok_c   = 1'b1;
          end else begin
            ok_c   = !(ra_r == wa_r && held_r == '0);
          end
        end
        frrm_pkg::KIND_CONSUME: begin
          if (held_r != '0) begin
            ra_nxt   = ra_r + REC_ADDR;
            addr_c   = ra_r + REC_ADDR;
            held_nxt = held_r - COUNT_W'(1);
            ok_c     = 1'b1;
          end
        end
        frrm_pkg::KIND_POLL: begin
          if (held_r != '0) begin
            if (!armed_r) begin
              armed_nxt = 1'b1;
              mark_nxt  = now_r;
            end
            if (poll_due) begin
              armed_nxt = 1'b0;
              ok_c      = 1'b1;
            end
          end else begin
            ra_nxt = wa_r;
            addr_c = wa_r;
          end
        end
        default: ;
      endcase
    end
  end

  // ring state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ra_r    <= frrm_pkg::REGION_START_RST;
      wa_r    <= frrm_pkg::REGION_START_RST;
      held_r  <= '0;
      mark_r  <= '0;
      armed_r <= 1'b0;
    end else begin
      ra_r    <= ra_nxt;
      wa_r    <= wa_nxt;
      held_r  <= held_nxt;
      mark_r  <= mark_nxt;
      armed_r <= armed_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_v_r) begin
      out_ok_r    <= ok_c;
      out_addr_r  <= addr_c;
      out_hlen_r  <= hlen_c;
      out_count_r <= held_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_flash_addr    = out_addr_r;
  assign out_header_length = out_hlen_r;
  assign out_record_count  = out_count_r;

  assign is_wr         = req_v_r && kind_r == frrm_pkg::KIND_WRITE;
  assign is_rd         = req_v_r && kind_r == frrm_pkg::KIND_READ;
  assign is_cons       = req_v_r && kind_r == frrm_pkg::KIND_CONSUME;
  assign is_poll       = req_v_r && kind_r == frrm_pkg::KIND_POLL;
  assign ring_empty    = ra_r == wa_r && held_r == '0;
  assign hlen_in_range = out_hlen_r >= frrm_pkg::HDR_EXTRA && out_hlen_r <= HLEN_MAX;

  `FRRM_ASSERT_NEXT(a_cons_dec, is_cons && held_r != '0, held_r == $past(held_r) - COUNT_W'(1))
  `FRRM_ASSERT_NEXT(a_cons_ok, is_cons && held_r != '0, out_ok_r)
  `FRRM_ASSERT_NEXT(a_empty_read, is_rd && ra_r < region_end_r && ring_empty, !out_ok_r)
  `FRRM_ASSERT_NEXT(a_empty_poll, is_poll && held_r == '0, ra_r == wa_r && !out_ok_r)
  `FRRM_ASSERT_NEXT(a_failed_write, is_wr && !wok_r, !out_ok_r && wa_r == $past(wa_w))
  `FRRM_ASSERT_SAME(a_hlen_range, out_valid_r && out_hlen_r != '0, hlen_in_range)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the flash record ring manager against its own pointer, count and
// timer model: directed corner requests, then random phases of ring traffic
// under several region and timer settings, with bursty request timing
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ADDR_W    = frrm_pkg::ADDR_W;
  localparam int COUNT_W   = frrm_pkg::COUNT_W;
  localparam int TICK_W    = frrm_pkg::TICK_W;
  localparam int LEN_W     = frrm_pkg::LEN_W;
  localparam int CFG_W     = frrm_pkg::CFG_W;
  localparam int CFG_IDX_W = frrm_pkg::CFG_IDX_W;

  localparam int REC_BYTES  = 256;
  localparam int SECT_BYTES = 4096;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 220;

  typedef struct packed {
    frrm_pkg::kind_t   kind;
    logic [LEN_W-1:0]  payload_len;
    logic              write_ok;
    logic [TICK_W-1:0] now_ticks;
  } ring_req_t;

  typedef struct packed {
    logic               ok;
    logic [ADDR_W-1:0]  flash_addr;
    logic [LEN_W-1:0]   header_length;
    logic [COUNT_W-1:0] record_count;
  } ring_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic [LEN_W-1:0] in_payload_len = '0;
  logic in_write_ok = 1'b0;
  logic [TICK_W-1:0] in_now_ticks = '0;
  logic out_valid;
  logic out_ok;
  logic [ADDR_W-1:0] out_flash_addr;
  logic [LEN_W-1:0] out_header_length;
  logic [COUNT_W-1:0] out_record_count;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  flash_record_ring_manager_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_payload_len(in_payload_len), .in_write_ok(in_write_ok),
    .in_now_ticks(in_now_ticks),
    .out_valid(out_valid), .out_ok(out_ok), .out_flash_addr(out_flash_addr),
    .out_header_length(out_header_length), .out_record_count(out_record_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // model of the ring: configuration and bookkeeping
  logic [ADDR_W-1:0]  m_region_start, m_region_end, m_read_addr, m_write_addr;
  logic [COUNT_W-1:0] m_max_records, m_held;
  logic [TICK_W-1:0]  m_wait_ticks, m_timer_mark;
  logic               m_timer_armed;

  ring_req_t request_q[$];
  ring_res_t outcome_q[$];
  int unsigned issued_count = 0;
  int unsigned taken_count = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic req_taken = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  ring_req_t drv_req;
  logic [TICK_W-1:0] tick_now = '0;
  logic [TICK_W-1:0] phase_wait;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic ring_apply(input ring_req_t r, output ring_res_t res);
    logic [ADDR_W:0] next_wr;
    logic [ADDR_W:0] bound;
    logic [ADDR_W:0] drop;
    logic [LEN_W-1:0] plen;
    res = '0;
    case (r.kind)
      frrm_pkg::KIND_WRITE: begin
        next_wr = {1'b0, m_write_addr} + (ADDR_W+1)'(REC_BYTES);
        if (next_wr >= {1'b0, m_region_end}) begin
          bound = {1'b0, m_region_start} + (ADDR_W+1)'(SECT_BYTES);
          m_write_addr = m_region_start;
          if ({1'b0, m_read_addr} < bound) begin
            drop = (bound - {1'b0, m_read_addr}) / (ADDR_W+1)'(REC_BYTES);
            m_held = (drop >= {9'd0, m_held}) ? '0 : m_held - drop[COUNT_W-1:0];
            m_read_addr = bound[ADDR_W-1:0];
          end
        end
        plen = (r.payload_len > frrm_pkg::MAX_PAYLOAD) ? frrm_pkg::MAX_PAYLOAD
                                                       : r.payload_len;
        res.header_length = plen + frrm_pkg::HDR_EXTRA;
        res.flash_addr = m_write_addr;
        if (r.write_ok) begin
          m_write_addr = m_write_addr + ADDR_W'(REC_BYTES);
          m_held = (m_held >= m_max_records) ? m_max_records : m_held + 1'b1;
          res.ok = 1'b1;
        end
      end
      frrm_pkg::KIND_READ: begin
        if (m_read_addr >= m_region_end) begin
          m_read_addr = m_region_start;
          res.ok = 1'b1;
        end else begin
          res.ok = !(m_read_addr == m_write_addr && m_held == 0);
        end
        res.flash_addr = m_read_addr;
      end
      frrm_pkg::KIND_CONSUME: begin
        if (m_held != 0) begin
          m_read_addr = m_read_addr + ADDR_W'(REC_BYTES);
          m_held = m_held - 1'b1;
          res.ok = 1'b1;
        end
        res.flash_addr = m_read_addr;
      end
      frrm_pkg::KIND_POLL: begin
        if (m_held != 0) begin
          if (!m_timer_armed) begin
            m_timer_armed = 1'b1;
            m_timer_mark = r.now_ticks;
          end
          if (r.now_ticks - m_timer_mark >= m_wait_ticks) begin
            m_timer_armed = 1'b0;
            res.ok = 1'b1;
          end
        end else begin
          m_read_addr = m_write_addr;
        end
        res.flash_addr = m_read_addr;
      end
      default: ;
    endcase
    res.record_count = m_held;
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // monitor and model update, all on the rising edge
  always @(posedge clk) begin
    ring_req_t seen;
    ring_res_t want;
    if (!rst_n) begin
      m_region_start = frrm_pkg::REGION_START_RST;
      m_region_end   = frrm_pkg::REGION_END_RST;
      m_max_records  = frrm_pkg::MAX_RECORDS_RST;
      m_wait_ticks   = frrm_pkg::WAIT_TICKS_RST;
      m_read_addr    = frrm_pkg::REGION_START_RST;
      m_write_addr   = frrm_pkg::REGION_START_RST;
      m_held         = '0;
      m_timer_mark   = '0;
      m_timer_armed  = 1'b0;
    end else begin
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          $display("%0t result with no request pending: expected none actual %h",
                   $time, {out_ok, out_flash_addr, out_header_length, out_record_count});
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          check_field("ok", 32'(want.ok), 32'(out_ok));
          check_field("flash_addr", 32'(want.flash_addr), 32'(out_flash_addr));
          check_field("header_length", 32'(want.header_length), 32'(out_header_length));
          check_field("record_count", 32'(want.record_count), 32'(out_record_count));
        end
      end
      if (start && !busy) begin
        seen.kind = frrm_pkg::kind_t'(in_kind);
        seen.payload_len = in_payload_len;
        seen.write_ok = in_write_ok;
        seen.now_ticks = in_now_ticks;
        ring_apply(seen, want);
        outcome_q.push_back(want);
        taken_count++;
      end
      if (cfg_we) begin
        case (frrm_pkg::cfg_idx_t'(cfg_index))
          frrm_pkg::CFG_REGION_START: m_region_start = cfg_wdata[ADDR_W-1:0];
          frrm_pkg::CFG_REGION_END:   m_region_end   = cfg_wdata[ADDR_W-1:0];
          frrm_pkg::CFG_MAX_RECORDS:  m_max_records  = cfg_wdata[COUNT_W-1:0];
          frrm_pkg::CFG_WAIT_TICKS:   m_wait_ticks   = cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end
    end
    req_taken <= rst_n && start && !busy;
  end

  // request driver: bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      start <= 1'b1;
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (request_q.size() != 0) begin
      drv_req = request_q.pop_front();
      in_kind <= drv_req.kind;
      in_payload_len <= drv_req.payload_len;
      in_write_ok <= drv_req.write_ok;
      in_now_ticks <= drv_req.now_ticks;
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic issue(frrm_pkg::kind_t kind, logic [LEN_W-1:0] plen, logic wok,
                       logic [TICK_W-1:0] now);
    ring_req_t r;
    r.kind = kind;
    r.payload_len = plen;
    r.write_ok = wok;
    r.now_ticks = now;
    request_q.push_back(r);
    issued_count++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (issued_count != taken_count || outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_regs(logic [CFG_W-1:0] rs, logic [CFG_W-1:0] re,
                          logic [CFG_W-1:0] mr, logic [CFG_W-1:0] wt);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= frrm_pkg::CFG_REGION_START; cfg_wdata <= rs;
    @(negedge clk);
    cfg_index <= frrm_pkg::CFG_REGION_END; cfg_wdata <= re;
    @(negedge clk);
    cfg_index <= frrm_pkg::CFG_MAX_RECORDS; cfg_wdata <= mr;
    @(negedge clk);
    cfg_index <= frrm_pkg::CFG_WAIT_TICKS; cfg_wdata <= wt;
    @(negedge clk);
    cfg_we <= 1'b0;
    phase_wait = wt;
    @(posedge clk);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned pick;
    frrm_pkg::kind_t kind;
    logic [LEN_W-1:0] plen;
    logic wok;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        kind = frrm_pkg::kind_t'($urandom_range(0, 3));
        issue(kind, LEN_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), $urandom);
      end else begin
        if (pick < 50) kind = frrm_pkg::KIND_WRITE;
        else if (pick < 65) kind = frrm_pkg::KIND_READ;
        else if (pick < 82) kind = frrm_pkg::KIND_CONSUME;
        else kind = frrm_pkg::KIND_POLL;
        plen = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, 255))
                                           : LEN_W'($urandom_range(0, 250));
        wok = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 49) == 0) tick_now = $urandom;
        else tick_now = tick_now + $urandom_range(0, phase_wait / 8 + 2);
        issue(kind, plen, wok, tick_now);
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] rs;
    logic [CFG_W-1:0] re;
    logic [CFG_W-1:0] hi;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty ring corners
    issue(frrm_pkg::KIND_READ, 8'hff, 1'b1, 32'h0);
    issue(frrm_pkg::KIND_CONSUME, 8'h00, 1'b0, 32'hffff_ffff);
    issue(frrm_pkg::KIND_POLL, 8'haa, 1'b1, 32'd5);
    drain();

    // tiny region: wrap, eviction, saturation, timer wraparound
    set_regs({8'hff, 24'h000000}, {8'ha5, 24'h000600}, 32'hffff_0004, 32'd16);
    issue(frrm_pkg::KIND_WRITE, 8'd0, 1'b0, 32'd0);
    issue(frrm_pkg::KIND_WRITE, 8'd0, 1'b1, 32'd0);
    issue(frrm_pkg::KIND_WRITE, 8'd250, 1'b1, 32'd0);
    issue(frrm_pkg::KIND_WRITE, 8'd251, 1'b1, 32'd0);
    issue(frrm_pkg::KIND_WRITE, 8'd255, 1'b1, 32'd0);
    issue(frrm_pkg::KIND_WRITE, 8'd128, 1'b1, 32'd0);
    issue(frrm_pkg::KIND_WRITE, 8'd1, 1'b1, 32'd0);
    issue(frrm_pkg::KIND_READ, 8'd0, 1'b0, 32'd0);
    issue(frrm_pkg::KIND_CONSUME, 8'd0, 1'b0, 32'd0);
    issue(frrm_pkg::KIND_WRITE, 8'd77, 1'b1, 32'd0);
    issue(frrm_pkg::KIND_POLL, 8'd0, 1'b0, 32'hffff_fff0);
    issue(frrm_pkg::KIND_POLL, 8'd0, 1'b0, 32'h0000_0005);
    issue(frrm_pkg::KIND_POLL, 8'd0, 1'b0, 32'h0000_0006);
    issue(frrm_pkg::KIND_POLL, 8'd0, 1'b0, 32'h0000_0007);
    issue(frrm_pkg::KIND_CONSUME, 8'd0, 1'b0, 32'd0);
    issue(frrm_pkg::KIND_CONSUME, 8'd0, 1'b0, 32'd0);
    issue(frrm_pkg::KIND_READ, 8'd0, 1'b0, 32'd0);
    issue(frrm_pkg::KIND_POLL, 8'd0, 1'b0, 32'd9);
    issue(frrm_pkg::KIND_READ, 8'd0, 1'b0, 32'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      hi = {8'($urandom_range(0, 255)), 24'd0};
      case (p)
        0: set_regs(hi | 32'h000000, 32'h002000, 32'h0000_ffff, 32'd50);
        1: set_regs(hi | 32'hffe000, 32'h00ffffff, 32'd7, 32'd0);
        2: set_regs(hi | 32'hffffff, hi, 32'd0, 32'hffff_ffff);
        3: set_regs($urandom, $urandom, $urandom, $urandom);
        7: set_regs(CFG_W'(frrm_pkg::REGION_START_RST), CFG_W'(frrm_pkg::REGION_END_RST),
                    CFG_W'(frrm_pkg::MAX_RECORDS_RST), CFG_W'(frrm_pkg::WAIT_TICKS_RST));
        default: begin
          rs = ADDR_W'($urandom);
          re = rs + $urandom_range(1, 40) * REC_BYTES
               + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0);
          set_regs(hi | rs, re,
                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 48),
                   ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 300));
        end
      endcase
      random_phase(PHASE_ITEMS);
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: flash_record_ring_manager_top.f
+incdir+rtl
rtl/frrm_pkg.sv
rtl/flash_record_ring_manager_top.sv
tb/tb_top.sv
